>>> design/mlsf_pkg.sv
`default_nettype none

package mlsf_pkg;

   localparam int MAX_LINE_PIXELS = 1024;
   localparam int BYTES_CAP = (MAX_LINE_PIXELS / 8 == 0) ? 1 : MAX_LINE_PIXELS / 8;

   localparam int THRESH_W = 8;
   localparam int LINE_W = 11;
   localparam int CSR_W = 11;
   localparam int COL_W = 10;

   localparam logic [7:0] WRITE_CMD = 8'h80;
   localparam logic [7:0] CLEAR_CMD = 8'h20;
   localparam logic [7:0] TRAILER_BYTE = 8'h00;
   localparam logic [7:0] END_BYTE = 8'h00;

   localparam logic CSR_GRAY_THRESHOLD = 1'b0;
   localparam logic CSR_LINE_PIXELS = 1'b1;

   typedef enum logic [2:0] {
      REQ_BEGIN,
      REQ_PIXEL,
      REQ_END,
      REQ_CLEAR,
      REQ_TICK
   } req_code_type;

   // up to three results produced by one input transaction
   typedef struct packed {
      logic [1:0]      count;
      logic            vcom;
      logic [2:0]      valid;
      logic [2:0]      eot;
      logic [2:0][7:0] data;
   } burst_type;

   function automatic logic [7:0] flip_bits(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = v[7-i];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> design/mlsf_fmt_core.sv
`default_nettype none

module mlsf_fmt_core
   import mlsf_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_we,
   input  wire logic                csr_index,
   input  wire logic [CSR_W-1:0]    csr_wdata,
   input  wire logic                accept,
   input  wire logic [2:0]          req_type,
   input  wire logic [7:0]          gray_pixel,
   input  wire logic [7:0]          first_row,
   output burst_type                burst
);

   logic [THRESH_W-1:0] thresh_ff;
   logic [LINE_W-1:0]   line_ff;
   logic [7:0]          acc_ff, acc_in;
   logic [2:0]          pos_ff, pos_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [7:0]          row_ff, row_in;
   logic                vcom_ff, vcom_in;

   logic [LINE_W-1:0] bytes_raw;
   logic [LINE_W-1:0] bpl;
   logic [LINE_W-1:0] col_next;
   logic [7:0]        acc_new;
   logic              need_addr;
   logic              need_trail;

   localparam logic [LINE_W-1:0] CAP = LINE_W'(BYTES_CAP);

   always_comb begin
      bytes_raw = {3'b000, line_ff[LINE_W-1:3]};
      if (bytes_raw == '0) begin
         bpl = LINE_W'(1);
      end else if (bytes_raw > CAP) begin
         bpl = CAP;
      end else begin
         bpl = bytes_raw;
      end
   end

   assign acc_new = acc_ff | ((gray_pixel >= thresh_ff) ? (8'h80 >> pos_ff) : 8'h00);
   assign col_next = LINE_W'(col_ff) + LINE_W'(1);
   assign need_addr = (col_ff == '0);
   assign need_trail = (col_next >= bpl);

   always_comb begin
      acc_in = acc_ff;
      pos_in = pos_ff;
      col_in = col_ff;
      row_in = row_ff;
      vcom_in = vcom_ff;
      burst = '0;
      burst.vcom = vcom_ff;
      case (req_type)
         REQ_BEGIN: begin
            row_in = first_row;
            acc_in = '0;
            pos_in = '0;
            col_in = '0;
            burst.count = 2'd1;
            burst.valid = 3'b001;
            burst.data[0] = WRITE_CMD;
         end
         REQ_PIXEL: begin
            if (pos_ff != 3'd7) begin
               acc_in = acc_new;
               pos_in = pos_ff + 3'd1;
            end else begin
               acc_in = '0;
               pos_in = '0;
               if (need_trail) begin
                  col_in = '0;
                  row_in = row_ff + 8'd1;
               end else begin
                  col_in = col_next[COL_W-1:0];
               end
               burst.count = 2'd1 + 2'(need_addr) + 2'(need_trail);
               burst.valid = 3'b111;
               burst.data[0] = need_addr ? flip_bits(row_ff + 8'd1) : acc_new;
               burst.data[1] = need_addr ? acc_new : TRAILER_BYTE;
               burst.data[2] = TRAILER_BYTE;
            end
         end
         REQ_END: begin
            burst.count = 2'd1;
            burst.valid = 3'b001;
            burst.eot = 3'b001;
            burst.data[0] = END_BYTE;
         end
         REQ_CLEAR: begin
            burst.count = 2'd2;
            burst.valid = 3'b011;
            burst.eot = 3'b010;
            burst.data[0] = CLEAR_CMD;
            burst.data[1] = 8'h00;
         end
         REQ_TICK: begin
            vcom_in = ~vcom_ff;
            burst.count = 2'd1;
            burst.vcom = ~vcom_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_W'(32);
         line_ff <= LINE_W'(400);
         acc_ff <= '0;
         pos_ff <= '0;
         col_ff <= '0;
         row_ff <= '0;
         vcom_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_GRAY_THRESHOLD: thresh_ff <= csr_wdata[THRESH_W-1:0];
               CSR_LINE_PIXELS: line_ff <= csr_wdata[LINE_W-1:0];
               default: begin
               end
            endcase
         end
         if (accept) begin
            acc_ff <= acc_in;
            pos_ff <= pos_in;
            col_ff <= col_in;
            row_ff <= row_in;
            vcom_ff <= vcom_in;
         end
      end
   end

endmodule

`default_nettype wire

>>> design/mlsf_burst_queue.sv
`default_nettype none

module mlsf_burst_queue
   import mlsf_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire burst_type  burst,
   output logic            can_push,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_byte_valid,
   output logic [7:0]      rsp_spi_byte,
   output logic            rsp_end_of_transfer,
   output logic            rsp_last_of_run,
   output logic            rsp_vcom_level
);

   burst_type  head_ff, pend_ff;
   logic       head_valid_ff, pend_valid_ff;
   logic [1:0] idx_ff;

   logic last;
   logic fire;
   logic pop;
   logic head_free;

   assign last = (idx_ff == head_ff.count - 2'd1);
   assign fire = head_valid_ff && rsp_ready;
   assign pop = fire && last;
   assign head_free = !head_valid_ff || pop;
   assign can_push = !pend_valid_ff;

   assign rsp_valid = head_valid_ff;
   assign rsp_last_of_run = last;
   assign rsp_vcom_level = head_ff.vcom;

   always_comb begin
      case (idx_ff)
         2'd0: begin
            rsp_byte_valid = head_ff.valid[0];
            rsp_spi_byte = head_ff.data[0];
            rsp_end_of_transfer = head_ff.eot[0];
         end
         2'd1: begin
            rsp_byte_valid = head_ff.valid[1];
            rsp_spi_byte = head_ff.data[1];
            rsp_end_of_transfer = head_ff.eot[1];
         end
         default: begin
            rsp_byte_valid = head_ff.valid[2];
            rsp_spi_byte = head_ff.data[2];
            rsp_end_of_transfer = head_ff.eot[2];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         if (fire && !last) begin
            idx_ff <= idx_ff + 2'd1;
         end
         if (head_free) begin
            idx_ff <= '0;
            if (pend_valid_ff) begin
               head_ff <= pend_ff;
               head_valid_ff <= 1'b1;
               pend_valid_ff <= 1'b0;
            end else if (push) begin
               head_ff <= burst;
               head_valid_ff <= 1'b1;
            end else begin
               head_valid_ff <= 1'b0;
            end
         end else if (push) begin
            pend_ff <= burst;
            pend_valid_ff <= 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

>>> design/memory_lcd_line_stream_formatter.sv
// memory lcd line stream formatter
// req channel: one transaction per request (begin, pixel, end, clear, vcom tick),
// valid/ready. rsp channel: one transaction per output byte or tick marker,
// valid/ready; last_of_run marks the final result of a request.
// csr port: csr_we with csr_index 0 (gray threshold) or 1 (line pixels),
// taken at the clock edge, no wait; write only while the block is idle.
// results of an accepted request are registered in the burst buffer and offered
// from there; they wait while an earlier burst is still being sent.
// throughput: one request per cycle while rsp_ready is high and each request
// makes at most one result; a longer burst holds rsp until all of it is taken.
// results are staged in a two-entry burst buffer (one burst being sent, one
// waiting), so a request is still accepted while a result waits on rsp_ready;
// req_ready drops only while a second burst is waiting.
// pixels that do not complete a byte make no result.
// reset: synchronous, clears line state, row, vcom and both buffers; the
// threshold returns to 32 and the line width to 400 pixels.
// a stalled receiver holds the current result steady until it is taken.
`default_nettype none

module memory_lcd_line_stream_formatter
   import mlsf_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_we,
   input  wire logic             csr_index,
   input  wire logic [CSR_W-1:0] csr_wdata,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [2:0]       req_type,
   input  wire logic [7:0]       req_gray_pixel,
   input  wire logic [7:0]       req_first_row,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic                  rsp_byte_valid,
   output logic [7:0]            rsp_spi_byte,
   output logic                  rsp_end_of_transfer,
   output logic                  rsp_last_of_run,
   output logic                  rsp_vcom_level
);

   burst_type burst;
   logic      accept;
   logic      can_push;

   assign req_ready = can_push;
   assign accept = req_valid && req_ready;

   mlsf_fmt_core u_core (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .accept     (accept),
      .req_type   (req_type),
      .gray_pixel (req_gray_pixel),
      .first_row  (req_first_row),
      .burst      (burst)
   );

   mlsf_burst_queue u_queue (
      .clock               (clock),
      .reset               (reset),
      .push                (accept && (burst.count != 2'd0)),
      .burst               (burst),
      .can_push            (can_push),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_byte_valid      (rsp_byte_valid),
      .rsp_spi_byte        (rsp_spi_byte),
      .rsp_end_of_transfer (rsp_end_of_transfer),
      .rsp_last_of_run     (rsp_last_of_run),
      .rsp_vcom_level      (rsp_vcom_level)
   );

endmodule

`default_nettype wire

>>> design/mlsf_checker.sv
`default_nettype none

module mlsf_checker
   import mlsf_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             csr_we,
   input wire logic             csr_index,
   input wire logic [CSR_W-1:0] csr_wdata,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic [2:0]       req_type,
   input wire logic [7:0]       req_gray_pixel,
   input wire logic [7:0]       req_first_row,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire logic             rsp_byte_valid,
   input wire logic [7:0]       rsp_spi_byte,
   input wire logic             rsp_end_of_transfer,
   input wire logic             rsp_last_of_run,
   input wire logic             rsp_vcom_level
);

   // stalled rsp transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_spi_byte)
         && $stable(rsp_last_of_run) && $stable(rsp_vcom_level))
      else $error("rsp transaction changed while stalled");

   // tick marker is a lone zero result
   a_tick_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_last_of_run && rsp_spi_byte == 8'h00
         && !rsp_end_of_transfer)
      else $error("bad vcom tick result");

   // end of transfer closes the run
   a_eot_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_transfer |-> rsp_last_of_run && rsp_byte_valid)
      else $error("end of transfer not on last byte of run");

   // vcom level only moves with a tick marker
   a_vcom_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_byte_valid ##1 rsp_valid && rsp_byte_valid
         |-> $stable(rsp_vcom_level))
      else $error("vcom level changed without a tick");

endmodule

bind memory_lcd_line_stream_formatter mlsf_checker u_checker (.*);

`default_nettype wire

>>> bench/mlsf_stream_checker.sv
`timescale 1ns / 100ps

module mlsf_stream_checker
   import mlsf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata,
   input  logic             req_valid,
   input  logic             req_ready,
   input  logic [2:0]       req_type,
   input  logic [7:0]       req_gray_pixel,
   input  logic [7:0]       req_first_row,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic             rsp_byte_valid,
   input  logic [7:0]       rsp_spi_byte,
   input  logic             rsp_end_of_transfer,
   input  logic             rsp_last_of_run,
   input  logic             rsp_vcom_level,
   output int               error_count,
   output int               pending_count,
   output int               request_count,
   output int               response_count,
   output int               line_count
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] spi_byte;
      logic       end_of_transfer;
      logic       last_of_run;
      logic       vcom_level;
   } spi_word_t;

   spi_word_t         spi_words_due[$];
   logic [7:0]        gray_threshold;
   logic [LINE_W-1:0] line_pixels;
   logic [7:0]        mono_byte;
   logic [2:0]        fill_bit;
   logic [COL_W-1:0]  bytes_done;
   logic [7:0]        panel_row;
   logic              vcom;

   function automatic logic [7:0] mirror_byte(input logic [7:0] v);
      return {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]};
   endfunction

   function automatic int bytes_per_line();
      int nb;
      nb = int'(line_pixels >> 3);
      if (nb == 0) begin
         nb = 1;
      end
      if (nb > BYTES_CAP) begin
         nb = BYTES_CAP;
      end
      return nb;
   endfunction

   function automatic spi_word_t make_word(input logic bv, input logic [7:0] data,
                                           input logic eot);
      return '{bv, data, eot, 1'b0, vcom};
   endfunction

   task automatic format_request(input logic [2:0] code, input logic [7:0] gray,
                                 input logic [7:0] start_row);
      spi_word_t  burst[3];
      int         n;
      logic [7:0] row_addr;
      n = 0;
      case (code)
         REQ_BEGIN: begin
            panel_row = start_row;
            mono_byte = '0;
            fill_bit = '0;
            bytes_done = '0;
            burst[n++] = make_word(1'b1, WRITE_CMD, 1'b0);
         end
         REQ_PIXEL: begin
            if (gray >= gray_threshold) begin
               mono_byte = mono_byte | (8'h80 >> fill_bit);
            end
            if (fill_bit != 3'd7) begin
               fill_bit = fill_bit + 3'd1;
            end else begin
               fill_bit = '0;
               if (bytes_done == '0) begin
                  row_addr = panel_row + 8'd1;
                  burst[n++] = make_word(1'b1, mirror_byte(row_addr), 1'b0);
               end
               burst[n++] = make_word(1'b1, mono_byte, 1'b0);
               mono_byte = '0;
               bytes_done = bytes_done + 1'b1;
               if (int'(bytes_done) >= bytes_per_line()) begin
                  burst[n++] = make_word(1'b1, TRAILER_BYTE, 1'b0);
                  bytes_done = '0;
                  panel_row = panel_row + 8'd1;
                  line_count++;
               end
            end
         end
         REQ_END: begin
            burst[n++] = make_word(1'b1, END_BYTE, 1'b1);
         end
         REQ_CLEAR: begin
            burst[n++] = make_word(1'b1, CLEAR_CMD, 1'b0);
            burst[n++] = make_word(1'b1, END_BYTE, 1'b1);
         end
         REQ_TICK: begin
            vcom = ~vcom;
            burst[n++] = make_word(1'b0, 8'h00, 1'b0);
         end
         default: begin
         end
      endcase
      for (int i = 0; i < n; i++) begin
         if (i == n - 1) begin
            burst[i].last_of_run = 1'b1;
         end
         spi_words_due.push_back(burst[i]);
      end
   endtask

   always @(posedge clock) begin : watch
      spi_word_t due;
      spi_word_t seen;
      if (reset) begin
         spi_words_due.delete();
         gray_threshold = 8'd32;
         line_pixels = 11'd400;
         mono_byte = '0;
         fill_bit = '0;
         bytes_done = '0;
         panel_row = '0;
         vcom = 1'b0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_GRAY_THRESHOLD) begin
               gray_threshold = csr_wdata[THRESH_W-1:0];
            end else begin
               line_pixels = csr_wdata[LINE_W-1:0];
            end
         end
         if (rsp_valid && rsp_ready) begin
            response_count++;
            seen = '{rsp_byte_valid, rsp_spi_byte, rsp_end_of_transfer, rsp_last_of_run,
                     rsp_vcom_level};
            if (spi_words_due.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT) begin
                  $display("%0t unexpected transaction: byte_valid %b byte %h eot %b last %b vcom %b",
                           $time, seen.byte_valid, seen.spi_byte, seen.end_of_transfer,
                           seen.last_of_run, seen.vcom_level);
               end
            end else begin
               due = spi_words_due.pop_front();
               if (seen !== due) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT) begin
                     $display("%0t transaction %0d expected: byte_valid %b byte %h eot %b last %b vcom %b",
                              $time, response_count, due.byte_valid, due.spi_byte,
                              due.end_of_transfer, due.last_of_run, due.vcom_level);
                     $display("%0t transaction %0d actual:   byte_valid %b byte %h eot %b last %b vcom %b",
                              $time, response_count, seen.byte_valid, seen.spi_byte,
                              seen.end_of_transfer, seen.last_of_run, seen.vcom_level);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            request_count++;
            format_request(req_type, req_gray_pixel, req_first_row);
         end
      end
      pending_count = spi_words_due.size();
   end

endmodule

>>> bench/tb_memory_lcd_line_stream_formatter.sv
`timescale 1ns / 100ps

module tb_memory_lcd_line_stream_formatter;
   import mlsf_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam logic [2:0] REQ_SPARE_LO = 3'd5;
   localparam logic [2:0] REQ_SPARE_HI = 3'd7;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_we;
   logic             csr_index;
   logic [CSR_W-1:0] csr_wdata;
   logic             req_valid;
   logic             req_ready;
   logic [2:0]       req_type;
   logic [7:0]       req_gray_pixel;
   logic [7:0]       req_first_row;
   logic             rsp_valid;
   logic             rsp_ready;
   logic             rsp_byte_valid;
   logic [7:0]       rsp_spi_byte;
   logic             rsp_end_of_transfer;
   logic             rsp_last_of_run;
   logic             rsp_vcom_level;

   int         error_count;
   int         pending_count;
   int         request_count;
   int         response_count;
   int         line_count;
   int         requests_sent;
   int         quiet_cycles;
   bit         gaps_on;
   bit         stalls_on;
   logic [7:0] cur_thresh;

   always #5 clock = ~clock;

   memory_lcd_line_stream_formatter i_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_type            (req_type),
      .req_gray_pixel      (req_gray_pixel),
      .req_first_row       (req_first_row),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_byte_valid      (rsp_byte_valid),
      .rsp_spi_byte        (rsp_spi_byte),
      .rsp_end_of_transfer (rsp_end_of_transfer),
      .rsp_last_of_run     (rsp_last_of_run),
      .rsp_vcom_level      (rsp_vcom_level)
   );

   mlsf_stream_checker i_checker (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_type            (req_type),
      .req_gray_pixel      (req_gray_pixel),
      .req_first_row       (req_first_row),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_byte_valid      (rsp_byte_valid),
      .rsp_spi_byte        (rsp_spi_byte),
      .rsp_end_of_transfer (rsp_end_of_transfer),
      .rsp_last_of_run     (rsp_last_of_run),
      .rsp_vcom_level      (rsp_vcom_level),
      .error_count         (error_count),
      .pending_count       (pending_count),
      .request_count       (request_count),
      .response_count      (response_count),
      .line_count          (line_count)
   );

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // receiver: ready and stall stretches of random length; stalls only with stalls_on
   initial begin
      int span;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         span = $urandom_range(1, 16);
         rsp_ready <= !(stalls_on && ($urandom_range(0, 2) == 0));
         repeat (span - 1) @(negedge clock);
      end
   end

   function automatic logic [7:0] pick_gray();
      case ($urandom_range(0, 5))
         0: return cur_thresh;
         1: return cur_thresh - 8'd1;
         2: return 8'h00;
         3: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] pick_row();
      case ($urandom_range(0, 3))
         0: return 8'd0;
         1: return 8'd254;
         2: return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_item(input logic [2:0] code, input logic [7:0] gray,
                            input logic [7:0] row);
      int gap;
      if (gaps_on && ($urandom_range(0, 3) == 0)) begin
         gap = $urandom_range(1, 16);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_type <= code;
      req_gray_pixel <= gray;
      req_first_row <= row;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (code <= REQ_TICK) begin
         requests_sent++;
      end
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_config(input logic [7:0] thr, input logic [LINE_W-1:0] width);
      settle();
      csr_we <= 1'b1;
      csr_index <= CSR_GRAY_THRESHOLD;
      csr_wdata <= {{(CSR_W - THRESH_W){1'b0}}, thr};
      @(negedge clock);
      csr_index <= CSR_LINE_PIXELS;
      csr_wdata <= width;
      @(negedge clock);
      csr_we <= 1'b0;
      cur_thresh = thr;
   endtask

   // mostly framed line transfers with random content, some noise between them
   task automatic run_random(input int target);
      int start;
      int run_len;
      start = requests_sent;
      while (requests_sent - start < target) begin
         if ($urandom_range(0, 9) < 7) begin
            send_item(REQ_BEGIN, 8'($urandom_range(0, 255)), pick_row());
            run_len = $urandom_range(1, 40);
            for (int k = 0; k < run_len; k++) begin
               if ($urandom_range(0, 19) == 0) begin
                  send_item(REQ_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
               end
               send_item(REQ_PIXEL, pick_gray(), 8'($urandom_range(0, 255)));
            end
            send_item(REQ_END, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end else begin
            case ($urandom_range(0, 4))
               0: send_item(REQ_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
               1: send_item(REQ_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
               2: send_item(3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI)),
                            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
               3: send_item(REQ_PIXEL, pick_gray(), 8'($urandom_range(0, 255)));
               default: begin
                  send_item(REQ_BEGIN, 8'($urandom_range(0, 255)), pick_row());
                  run_len = $urandom_range(1, 7);
                  for (int k = 0; k < run_len; k++) begin
                     send_item(REQ_PIXEL, pick_gray(), 8'($urandom_range(0, 255)));
                  end
               end
            endcase
         end
      end
   endtask

   initial begin
      logic [7:0] stray_gray [8];
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_GRAY_THRESHOLD;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_type = REQ_BEGIN;
      req_gray_pixel = '0;
      req_first_row = '0;
      gaps_on = 1'b1;
      stalls_on = 1'b1;
      cur_thresh = 8'd32;
      requests_sent = 0;
      quiet_cycles = 0;
      stray_gray = '{8'd31, 8'd32, 8'd33, 8'd0, 8'd255, 8'd32, 8'd31, 8'd255};
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed: ticks, spare codes, clear, end, pixels with no begin, begin mid-line
      send_item(REQ_TICK, 8'h00, 8'h00);
      send_item(REQ_TICK, 8'hFF, 8'hFF);
      send_item(REQ_SPARE_LO, 8'hFF, 8'hFF);
      send_item(REQ_SPARE_HI, 8'h00, 8'h00);
      send_item(REQ_CLEAR, 8'h00, 8'h00);
      send_item(REQ_END, 8'h00, 8'h00);
      foreach (stray_gray[k]) begin
         send_item(REQ_PIXEL, stray_gray[k], 8'h00);
      end
      send_item(REQ_BEGIN, 8'h00, 8'd254);
      send_item(REQ_PIXEL, 8'hFF, 8'h00);
      send_item(REQ_PIXEL, 8'hFF, 8'h00);
      send_item(REQ_BEGIN, 8'h00, 8'd255);
      foreach (stray_gray[k]) begin
         send_item(REQ_PIXEL, ~stray_gray[k], 8'h00);
      end
      send_item(REQ_END, 8'h00, 8'h00);

      run_random(20);
      set_config(8'd255, 11'd8);
      run_random(20);
      set_config(8'd0, 11'd0);
      run_random(15);
      set_config(8'd128, 11'd13);
      run_random(15);
      set_config(8'($urandom_range(0, 255)), 11'd1024);
      run_random(15);
      set_config(8'($urandom_range(0, 255)), 11'd16);
      run_random(20);

      // oversized width
      set_config(8'($urandom_range(0, 255)), 11'd2047);
      send_item(REQ_BEGIN, 8'h00, 8'd254);
      for (int k = 0; k < 24; k++) begin
         send_item(REQ_PIXEL, pick_gray(), 8'($urandom_range(0, 255)));
      end
      send_item(REQ_END, 8'h00, 8'h00);

      set_config(8'($urandom_range(0, 255)), 11'd24);
      gaps_on = 1'b0;
      stalls_on = 1'b0;
      run_random(30);

      settle();
      $display("run covered %0d requests, %0d output transactions and %0d finished lines",
               request_count, response_count, line_count);
      $display("thresholds 0 to 255, line widths 0 to 2047 pixels, with and without idling");
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
